// ----- rtl/pslu_pkg.sv -----
// Package for the per-step latency statistics unit.
// Holds the state type, status and register codes, time constants and the entry layout.
// No dependencies.
`default_nettype none

package pslu_pkg;

    localparam int unsigned DATA_W     = 64;
    localparam int unsigned CFG_W      = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned PERIOD_W   = 52;
    localparam int unsigned SLOW_W     = 42;

    localparam logic [19:0] US_PER_SECOND = 20'd1000000;
    localparam logic [9:0]  US_PER_MS     = 10'd1000;

    localparam logic [PERIOD_W-1:0] PERIOD_US_RESET  = PERIOD_W'(60 * 1000000);
    localparam logic [CFG_W-1:0]    THRESHOLD_RESET  = CFG_W'(1000);
    localparam logic [SLOW_W-1:0]   SLOW_US_RESET    = SLOW_W'(1000 * 1000);

    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LIMIT       = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_RECORDED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REPORTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ID   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] sum;
        logic [DATA_W-1:0] max;
        logic [DATA_W-1:0] last;
    } entry_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/pslu_div.sv -----
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Uses pslu_pkg for widths and the control/status structs.
`default_nettype none

module pslu_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pslu_pkg::div_ctrl_t           ctrl,
    input  wire logic [pslu_pkg::DATA_W-1:0]   dividend,
    input  wire logic [pslu_pkg::DATA_W-1:0]   divisor,
    output pslu_pkg::div_stat_t                stat,
    output logic      [pslu_pkg::DATA_W-1:0]   quotient
);

    localparam int unsigned W   = pslu_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;

    always_comb begin
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(W);
        end else if (cnt_reg != '0) begin
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/per_step_latency_statistics_unit.sv -----
// Sequence: an accepted transaction passes ST_LOOK, ST_UPD and ST_FIN; a report
// adds ST_DIV (the restoring divider) before ST_FIN, and an out-of-range id goes
// straight to ST_FIN, which waits while the output register is full and not taken.
// s_ready is high only between transactions, and a finished result waits in the
// output register while the next transaction is taken.
// Reset clears control state and entry valid bits, loads config defaults; uses pslu_div.
`default_nettype none

module per_step_latency_statistics_unit #(
    parameter int unsigned NUM_STEPS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_we,
    input  wire logic [pslu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pslu_pkg::CFG_W-1:0]        cfg_wdata,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [6:0]                        s_step_id,
    input  wire logic [pslu_pkg::DATA_W-1:0]       s_begin_time_us,
    input  wire logic [pslu_pkg::DATA_W-1:0]       s_end_time_us,
    input  wire logic                              s_has_path,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [pslu_pkg::STATUS_W-1:0]          m_status,
    output logic                                   m_slow_flag,
    output logic [pslu_pkg::DATA_W-1:0]            m_report_average,
    output logic [pslu_pkg::DATA_W-1:0]            m_report_max,
    output logic [pslu_pkg::DATA_W-1:0]            m_report_total,
    output logic [pslu_pkg::DATA_W-1:0]            m_report_count
);

    localparam int unsigned AW = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
    localparam int unsigned W  = pslu_pkg::DATA_W;

    // configuration; the period and slow limit are stored pre-scaled to microseconds
    logic [pslu_pkg::PERIOD_W-1:0] period_us_reg;
    logic [pslu_pkg::CFG_W-1:0]    threshold_reg;
    logic [pslu_pkg::SLOW_W-1:0]   slow_us_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_us_reg <= pslu_pkg::PERIOD_US_RESET;
            threshold_reg <= pslu_pkg::THRESHOLD_RESET;
            slow_us_reg   <= pslu_pkg::SLOW_US_RESET;
        end else if (cfg_we) begin
            priority case (cfg_index)
                pslu_pkg::CFG_REPORT_PERIOD: begin
                    period_us_reg <= pslu_pkg::PERIOD_W'(cfg_wdata)
                                     * pslu_pkg::PERIOD_W'(pslu_pkg::US_PER_SECOND);
                end
                pslu_pkg::CFG_REPORT_THRESHOLD: begin
                    threshold_reg <= cfg_wdata;
                end
                pslu_pkg::CFG_SLOW_LIMIT: begin
                    slow_us_reg <= pslu_pkg::SLOW_W'(cfg_wdata)
                                   * pslu_pkg::SLOW_W'(pslu_pkg::US_PER_MS);
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer
    pslu_pkg::state_t state_reg, state_next;
    logic accept;
    logic bad_id;
    logic mem_we;
    logic out_load;
    logic report;
    pslu_pkg::div_ctrl_t div_ctrl;
    pslu_pkg::div_stat_t div_stat;

    // transaction work registers
    logic [AW-1:0]  addr_reg;
    logic           bad_reg;
    logic           path_reg;
    logic [W-1:0]   end_reg;
    logic [W-1:0]   cost_reg;
    logic [W-1:0]   cnt_new_reg;
    logic [W-1:0]   sum_new_reg;
    logic [W-1:0]   max_new_reg;
    logic [W-1:0]   elapsed_reg;
    logic           slow_reg;
    logic           report_reg;
    logic [W-1:0]   quotient;

    // entry store
    pslu_pkg::entry_t mem [NUM_STEPS];
    logic [NUM_STEPS-1:0] vld_reg;
    pslu_pkg::entry_t rd_row_reg;
    logic             rd_vld_reg;
    pslu_pkg::entry_t cur_row;
    pslu_pkg::entry_t wr_row;

    assign bad_id = ({1'b0, s_step_id} >= 8'(NUM_STEPS));
    assign accept = s_valid && s_ready;
    assign report = (elapsed_reg > {{(W - pslu_pkg::PERIOD_W){1'b0}}, period_us_reg})
                 || (cnt_new_reg > {{(W - pslu_pkg::CFG_W){1'b0}}, threshold_reg});

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        mem_we         = 1'b0;
        out_load       = 1'b0;
        div_ctrl.start = 1'b0;
        unique case (state_reg)
            pslu_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = bad_id ? pslu_pkg::ST_FIN : pslu_pkg::ST_LOOK;
                end
            end
            pslu_pkg::ST_LOOK: begin
                state_next = pslu_pkg::ST_UPD;
            end
            pslu_pkg::ST_UPD: begin
                mem_we = 1'b1;
                if (report && (cnt_new_reg != '0)) begin
                    div_ctrl.start = 1'b1;
                    state_next     = pslu_pkg::ST_DIV;
                end else begin
                    state_next = pslu_pkg::ST_FIN;
                end
            end
            pslu_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = pslu_pkg::ST_FIN;
                end
            end
            pslu_pkg::ST_FIN: begin
                if (!m_valid || m_ready) begin
                    out_load   = 1'b1;
                    state_next = pslu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pslu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pslu_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // entry store access
    assign cur_row = rd_vld_reg ? rd_row_reg : '0;

    always_comb begin
        if (report) begin
            wr_row.count = '0;
            wr_row.sum   = '0;
            wr_row.max   = '0;
            wr_row.last  = end_reg;
        end else begin
            wr_row.count = cnt_new_reg;
            wr_row.sum   = sum_new_reg;
            wr_row.max   = max_new_reg;
            wr_row.last  = cur_row.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_reg] <= wr_row;
        end
        if (accept) begin
            rd_row_reg <= mem[s_step_id[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                vld_reg[addr_reg] <= 1'b1;
            end
            if (accept) begin
                rd_vld_reg <= vld_reg[s_step_id[AW-1:0]];
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg <= s_step_id[AW-1:0];
            bad_reg  <= bad_id;
            path_reg <= s_has_path;
            end_reg  <= s_end_time_us;
            cost_reg <= s_end_time_us - s_begin_time_us;
        end
        if (state_reg == pslu_pkg::ST_LOOK) begin
            cnt_new_reg <= cur_row.count + 1'b1;
            sum_new_reg <= cur_row.sum + cost_reg;
            max_new_reg <= (cost_reg > cur_row.max) ? cost_reg : cur_row.max;
            elapsed_reg <= end_reg - cur_row.last;
            slow_reg    <= path_reg
                        && (cost_reg > {{(W - pslu_pkg::SLOW_W){1'b0}}, slow_us_reg});
        end
        if (state_reg == pslu_pkg::ST_UPD) begin
            report_reg <= report;
        end
    end

    pslu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (sum_new_reg),
        .divisor  (cnt_new_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // output register
    logic m_valid_reg, m_valid_next;
    logic [pslu_pkg::STATUS_W-1:0] m_status_reg;
    logic                          m_slow_reg;
    logic [W-1:0]                  m_avg_reg, m_max_reg, m_total_reg, m_count_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (bad_reg) begin
                m_status_reg <= pslu_pkg::STATUS_BAD_ID;
                m_slow_reg   <= 1'b0;
                m_avg_reg    <= '0;
                m_max_reg    <= '0;
                m_total_reg  <= '0;
                m_count_reg  <= '0;
            end else if (report_reg) begin
                m_status_reg <= pslu_pkg::STATUS_REPORTED;
                m_slow_reg   <= slow_reg;
                m_avg_reg    <= (cnt_new_reg != '0) ? quotient : '0;
                m_max_reg    <= max_new_reg;
                m_total_reg  <= sum_new_reg;
                m_count_reg  <= cnt_new_reg;
            end else begin
                m_status_reg <= pslu_pkg::STATUS_RECORDED;
                m_slow_reg   <= slow_reg;
                m_avg_reg    <= '0;
                m_max_reg    <= '0;
                m_total_reg  <= '0;
                m_count_reg  <= '0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_slow_flag      = m_slow_reg;
    assign m_report_average = m_avg_reg;
    assign m_report_max     = m_max_reg;
    assign m_report_total   = m_total_reg;
    assign m_report_count   = m_count_reg;

endmodule

`default_nettype wire
